FILE: rtl/core/wsrf_pkg.sv
package wsrf_pkg;

    localparam int SPEED_BITS_DEFAULT = 7;
    localparam int GOAL_BITS          = 7;
    localparam int MOTION_BITS        = 3;
    localparam int MOTOR_COUNT        = 4;
    localparam int MOTOR_IDX_BITS     = 2;
    localparam int ADDR_BITS          = 8;
    localparam int TYPE_BITS          = 8;
    localparam int FRAME_BITS         = 24;
    localparam int QUEUE_DEPTH        = 2;
    localparam int QUEUE_PTR_BITS     = 1;

    typedef enum logic [MOTION_BITS-1:0] {
        MOTION_FWD   = 3'd0,
        MOTION_RIGHT = 3'd1,
        MOTION_BACK  = 3'd2,
        MOTION_LEFT  = 3'd3,
        MOTION_CW    = 3'd4,
        MOTION_CCW   = 3'd5,
        MOTION_STOP  = 3'd6
    } motion_t;

    // Bit i of the pattern is the direction of motor i+1.
    function automatic logic [MOTOR_COUNT-1:0] wheel_pattern(input logic [MOTION_BITS-1:0] m);
        logic [MOTOR_COUNT-1:0] p;
        case (m)
            MOTION_FWD:   p = 4'b0000;
            MOTION_RIGHT: p = 4'b0011;
            MOTION_BACK:  p = 4'b1111;
            MOTION_LEFT:  p = 4'b1100;
            MOTION_CW:    p = 4'b0101;
            MOTION_CCW:   p = 4'b1010;
            default:      p = 4'b0000;
        endcase
        return p;
    endfunction

endpackage

FILE: rtl/core/wsrf_front.sv
module wsrf_front #(
    parameter int SPEED_BITS = wsrf_pkg::SPEED_BITS_DEFAULT
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            push,
    input  logic                                            cmd,
    input  logic [wsrf_pkg::MOTION_BITS-1:0]                motion,
    input  logic [wsrf_pkg::GOAL_BITS-1:0]                  goal_speed,
    input  logic                                            fifo_full,
    output logic                                            fifo_wr,
    output logic [wsrf_pkg::MOTOR_COUNT+SPEED_BITS-1:0]     fifo_wdata
);
    import wsrf_pkg::*;

    localparam int CmpW = (SPEED_BITS > GOAL_BITS) ? SPEED_BITS : GOAL_BITS;

    logic [MOTION_BITS-1:0] cur_motion_reg, cur_motion_next;
    logic [SPEED_BITS-1:0]  cur_speed_reg, cur_speed_next;
    logic [MOTOR_COUNT-1:0] dirs_reg, dirs_next;
    logic [MOTION_BITS-1:0] pend_motion_reg, pend_motion_next;
    logic [SPEED_BITS-1:0]  pend_speed_reg, pend_speed_next;

    logic                   accept;
    logic                   emit;
    logic [MOTION_BITS-1:0] motion_clamped;
    logic [CmpW-1:0]        goal_wide;
    logic [CmpW-1:0]        max_wide;
    logic [CmpW-1:0]        goal_sat;

    assign accept         = push && !fifo_full;
    assign motion_clamped = (motion > MOTION_STOP) ? MOTION_STOP : motion;
    assign goal_wide      = CmpW'(goal_speed);
    assign max_wide       = CmpW'({SPEED_BITS{1'b1}});
    assign goal_sat       = (goal_wide > max_wide) ? max_wide : goal_wide;

    always_comb
    begin
        cur_motion_next  = cur_motion_reg;
        cur_speed_next   = cur_speed_reg;
        dirs_next        = dirs_reg;
        pend_motion_next = pend_motion_reg;
        pend_speed_next  = pend_speed_reg;
        emit             = 1'b0;
        if (accept)
        begin
            if (cmd)
            begin
                pend_motion_next = motion_clamped;
                pend_speed_next  = (motion_clamped == MOTION_STOP) ?
                                   '0 : goal_sat[SPEED_BITS-1:0];
            end
            else if (cur_motion_reg != pend_motion_reg && cur_speed_reg != '0)
            begin
                // Still winding down under the old wheel pattern.
                cur_speed_next = cur_speed_reg - 1'b1;
                emit           = 1'b1;
            end
            else
            begin
                if (cur_motion_reg != pend_motion_reg)
                begin
                    cur_motion_next = pend_motion_reg;
                    dirs_next       = wheel_pattern(pend_motion_reg);
                end
                if (cur_speed_reg != pend_speed_reg)
                begin
                    emit = 1'b1;
                    if (cur_speed_reg > pend_speed_reg)
                    begin
                        cur_speed_next = cur_speed_reg - 1'b1;
                    end
                    else
                    begin
                        cur_speed_next = cur_speed_reg + 1'b1;
                    end
                end
            end
        end
    end

    assign fifo_wr    = emit;
    assign fifo_wdata = {dirs_next, cur_speed_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_motion_reg  <= MOTION_STOP;
            cur_speed_reg   <= '0;
            dirs_reg        <= '0;
            pend_motion_reg <= MOTION_STOP;
            pend_speed_reg  <= '0;
        end
        else
        begin
            cur_motion_reg  <= cur_motion_next;
            cur_speed_reg   <= cur_speed_next;
            dirs_reg        <= dirs_next;
            pend_motion_reg <= pend_motion_next;
            pend_speed_reg  <= pend_speed_next;
        end
    end

endmodule

FILE: rtl/core/wsrf_fifo.sv
module wsrf_fifo #(
    parameter int WIDTH = wsrf_pkg::MOTOR_COUNT + wsrf_pkg::SPEED_BITS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             rd,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);
    import wsrf_pkg::*;

    logic [WIDTH-1:0]          mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_BITS:0]   count_reg, count_next;
    logic                      do_wr;
    logic                      do_rd;

    assign full  = (count_reg == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/core/wsrf_back.sv
module wsrf_back #(
    parameter int SPEED_BITS = wsrf_pkg::SPEED_BITS_DEFAULT
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        fifo_empty,
    input  logic [wsrf_pkg::MOTOR_COUNT+SPEED_BITS-1:0] fifo_rdata,
    output logic                                        fifo_rd,
    output logic [wsrf_pkg::FRAME_BITS-1:0]             frame,
    output logic                                        last,
    output logic                                        empty,
    input  logic                                        pop
);
    import wsrf_pkg::*;

    localparam int RecW  = MOTOR_COUNT + SPEED_BITS;
    localparam int RawW  = ADDR_BITS + TYPE_BITS + 1 + SPEED_BITS;
    localparam int WideW = (RawW > FRAME_BITS) ? RawW : FRAME_BITS;
    localparam logic [MOTOR_IDX_BITS-1:0] LastIdx = MOTOR_IDX_BITS'(MOTOR_COUNT - 1);

    logic [RecW-1:0]           rec_reg, rec_next;
    logic                      valid_reg, valid_next;
    logic [MOTOR_IDX_BITS-1:0] idx_reg, idx_next;
    logic                      done_step;
    logic [MOTOR_COUNT-1:0]    dirs;
    logic [SPEED_BITS-1:0]     speed;
    logic [ADDR_BITS-1:0]      addr;
    logic [RawW-1:0]           raw;
    logic [WideW-1:0]          wide;

    // A step record is released after its fourth motor frame is transferred.
    assign done_step = valid_reg && pop && (idx_reg == LastIdx);
    assign fifo_rd   = !fifo_empty && (!valid_reg || done_step);

    always_comb
    begin
        rec_next   = rec_reg;
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (valid_reg && pop)
        begin
            idx_next = idx_reg + 1'b1;
            if (idx_reg == LastIdx)
            begin
                valid_next = 1'b0;
            end
        end
        if (fifo_rd)
        begin
            rec_next   = fifo_rdata;
            valid_next = 1'b1;
            idx_next   = '0;
        end
    end

    assign dirs  = rec_reg[RecW-1:SPEED_BITS];
    assign speed = rec_reg[SPEED_BITS-1:0];
    assign addr  = ADDR_BITS'(idx_reg) + 1'b1;
    assign raw   = {addr, {TYPE_BITS{1'b0}}, dirs[idx_reg], speed};
    assign wide  = WideW'(raw);

    assign frame = wide[FRAME_BITS-1:0];
    assign last  = (idx_reg == LastIdx);
    assign empty = !valid_reg;

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

FILE: rtl/core/wheel_speed_ramp_framer_core.sv
// Flow: a tick that changes the speed goes into the step queue and then into the idle serializer,
// which shows its first motor frame; a command updates the goal and yields no frames.
// Throughput: one item per cycle on the input side while the queue is not full; the serializer
// sends one frame per cycle while popped, so speed-changing ticks are paced at four frames each.
// Reset: the robot is stopped at speed zero with all wheel directions clear, and the
// step queue and frame serializer are empty.
module wheel_speed_ramp_framer_core #(
    parameter int SPEED_BITS = wsrf_pkg::SPEED_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic                              cmd,
    input  logic [wsrf_pkg::MOTION_BITS-1:0]  motion,
    input  logic [wsrf_pkg::GOAL_BITS-1:0]    goal_speed,
    output logic                              empty,
    input  logic                              pop,
    output logic [wsrf_pkg::FRAME_BITS-1:0]   frame,
    output logic                              last
);
    import wsrf_pkg::*;

    localparam int RecW = MOTOR_COUNT + SPEED_BITS;

    logic            fifo_wr;
    logic [RecW-1:0] fifo_wdata;
    logic            fifo_rd;
    logic [RecW-1:0] fifo_rdata;
    logic            fifo_full;
    logic            fifo_empty;

    assign full = fifo_full;

    wsrf_front #(
        .SPEED_BITS (SPEED_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .cmd        (cmd),
        .motion     (motion),
        .goal_speed (goal_speed),
        .fifo_full  (fifo_full),
        .fifo_wr    (fifo_wr),
        .fifo_wdata (fifo_wdata)
    );

    wsrf_fifo #(
        .WIDTH (RecW)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (fifo_wr),
        .wdata (fifo_wdata),
        .rd    (fifo_rd),
        .rdata (fifo_rdata),
        .full  (fifo_full),
        .empty (fifo_empty)
    );

    wsrf_back #(
        .SPEED_BITS (SPEED_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .fifo_rdata (fifo_rdata),
        .fifo_rd    (fifo_rd),
        .frame      (frame),
        .last       (last),
        .empty      (empty),
        .pop        (pop)
    );

    // The front never produces a step record while the queue is full.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_wr |-> !fifo_full)
        else $error("step record written into a full queue");

    // The serializer only pulls a record that exists.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_rd |-> !fifo_empty)
        else $error("step record read from an empty queue");

    // The serializer drains the queue, so a full queue means it is busy.
    a_full_implies_busy: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_full |-> !empty)
        else $error("queue full while the frame serializer is idle");

endmodule

FILE: verif/wheel_speed_ramp_framer_core_tb.sv
`timescale 1ns / 100ps

module wheel_speed_ramp_framer_core_tb;

    import wsrf_pkg::*;

    localparam int SPEED_W         = SPEED_BITS_DEFAULT;
    localparam int TOTAL_ITEMS     = 350;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RAMP_TICKS      = 130;
    localparam int DRAIN_CYCLES    = 20;

    logic                   clk;
    logic                   rst_n;
    logic                   push;
    logic                   full;
    logic                   cmd;
    logic [MOTION_BITS-1:0] motion;
    logic [GOAL_BITS-1:0]   goal_speed;
    logic                   empty;
    logic                   pop;
    logic [FRAME_BITS-1:0]  frame;
    logic                   last;

    int send_idle_pct;
    int recv_stall_pct;
    int counted_items;
    bit hold_off;

    // Tracks the ramp state of the robot and the motor frames still owed by the block.
    class frame_scoreboard;
        motion_t                cur_motion;
        motion_t                goal_motion;
        logic [SPEED_W-1:0]     cur_speed;
        logic [SPEED_W-1:0]     goal_spd;
        logic [MOTOR_COUNT-1:0] dirs;
        logic [FRAME_BITS-1:0]  exp_frame[$];
        logic                   exp_last[$];
        int                     errors;

        function new();
            cur_motion  = MOTION_STOP;
            goal_motion = MOTION_STOP;
            cur_speed   = '0;
            goal_spd    = '0;
            dirs        = '0;
            errors      = 0;
        endfunction

        function logic [MOTOR_COUNT-1:0] pattern_of(motion_t m);
            case (m)
                MOTION_RIGHT: return 4'b0011;
                MOTION_BACK:  return 4'b1111;
                MOTION_LEFT:  return 4'b1100;
                MOTION_CW:    return 4'b0101;
                MOTION_CCW:   return 4'b1010;
                default:      return 4'b0000;
            endcase
        endfunction

        function int queue_frames();
            for (int i = 0; i < MOTOR_COUNT; i++)
            begin
                exp_frame.push_back({ADDR_BITS'(i + 1), {TYPE_BITS{1'b0}}, dirs[i], cur_speed});
                exp_last.push_back(i == MOTOR_COUNT - 1);
            end
            return MOTOR_COUNT;
        endfunction

        // Returns the number of frames that the transfer is expected to produce.
        function int note_item(logic c, logic [MOTION_BITS-1:0] m, logic [GOAL_BITS-1:0] g);
            motion_t req;
            if (c)
            begin
                req = (m > MOTION_STOP) ? MOTION_STOP : motion_t'(m);
                goal_motion = req;
                goal_spd = (req == MOTION_STOP) ? '0 : SPEED_W'(g);
                return 0;
            end
            if (cur_motion != goal_motion)
            begin
                if (cur_speed != 0)
                begin
                    cur_speed--;
                    return queue_frames();
                end
                cur_motion = goal_motion;
                dirs = pattern_of(cur_motion);
            end
            if (cur_speed == goal_spd)
                return 0;
            if (cur_speed > goal_spd)
                cur_speed--;
            else
                cur_speed++;
            return queue_frames();
        endfunction

        function void check_frame(logic [FRAME_BITS-1:0] f, logic l);
            logic [FRAME_BITS-1:0] ef;
            logic                  el;
            if (exp_frame.size() == 0)
            begin
                $error("frame %h arrived with no frame expected", f);
                errors++;
                return;
            end
            ef = exp_frame.pop_front();
            el = exp_last.pop_front();
            if (f !== ef)
            begin
                $error("frame mismatch: expected %h, actual %h", ef, f);
                errors++;
            end
            if (l !== el)
            begin
                $error("last mismatch: expected %0b, actual %0b", el, l);
                errors++;
            end
        endfunction

        function int pending();
            return exp_frame.size();
        endfunction
    endclass

    frame_scoreboard sb = new();

    wheel_speed_ramp_framer_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cmd        (cmd),
        .motion     (motion),
        .goal_speed (goal_speed),
        .empty      (empty),
        .pop        (pop),
        .frame      (frame),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Push stays high from one transfer to the next unless an idle gap is drawn.
    task automatic send_item(input logic c, input logic [MOTION_BITS-1:0] m,
                             input logic [GOAL_BITS-1:0] g);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        cmd        <= c;
        motion     <= m;
        goal_speed <= g;
        @(posedge clk);
        while (full)
            @(posedge clk);
        void'(sb.note_item(c, m, g));
        counted_items++;
    endtask

    // Ticks carry random motion and goal bits, which the block must ignore.
    task automatic send_ticks(input int n);
        repeat (n)
            send_item(1'b0, MOTION_BITS'($urandom_range(7)), GOAL_BITS'($urandom_range(127)));
    endtask

    task automatic send_move(input logic [MOTION_BITS-1:0] m, input logic [GOAL_BITS-1:0] g);
        send_item(1'b1, m, g);
    endtask

    initial
    begin
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && pop && !empty)
                sb.check_frame(frame, last);
            pop <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        int pick;
        int goal_pick;
        int loop_start;
        logic [GOAL_BITS-1:0] goal;
        rst_n      <= 1'b0;
        push       <= 1'b0;
        cmd        <= 1'b0;
        motion     <= MOTION_STOP;
        goal_speed <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A tick out of reset has nothing to do.
        send_ticks(1);
        send_move(MOTION_FWD, 7'd3);
        send_ticks(4);
        // Reversing ramps down under the old pattern, then switches at zero.
        send_move(MOTION_BACK, 7'd2);
        send_ticks(4);
        // A stop goal ignores the requested speed.
        send_move(MOTION_STOP, 7'd127);
        send_ticks(3);
        // Motion code 7 behaves as stop.
        send_move(3'd7, 7'd85);
        send_ticks(1);
        send_move(MOTION_RIGHT, 7'd1);
        send_ticks(1);
        send_move(MOTION_LEFT, 7'd42);
        send_ticks(2);
        send_move(MOTION_CW, 7'd1);
        send_ticks(2);

        // Long ramp to full speed while the receiver holds off, so the input backs up.
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off <= 1'b0;
            end
        join_none
        send_move(MOTION_CCW, 7'd127);
        send_ticks(RAMP_TICKS);

        loop_start = counted_items;
        while (counted_items < TOTAL_ITEMS)
        begin
            case ((counted_items - loop_start) * 4 / (TOTAL_ITEMS - loop_start))
                0:
                begin
                    send_idle_pct  <= 0;
                    recv_stall_pct <= 0;
                end
                1:
                begin
                    send_idle_pct  <= 80;
                    recv_stall_pct <= 0;
                end
                2:
                begin
                    send_idle_pct  <= 0;
                    recv_stall_pct <= 80;
                end
                default:
                begin
                    send_idle_pct  <= 6;
                    recv_stall_pct <= 6;
                end
            endcase
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                send_item(1'($urandom_range(1)), MOTION_BITS'($urandom_range(7)),
                          GOAL_BITS'($urandom_range(127)));
            end
            else
            begin
                goal_pick = $urandom_range(99);
                if (goal_pick < 10)
                    goal = 7'd127;
                else if (goal_pick < 20)
                    goal = 7'd0;
                else if (goal_pick < 55)
                    goal = GOAL_BITS'($urandom_range(1, 8));
                else
                    goal = GOAL_BITS'($urandom_range(127));
                send_move(MOTION_BITS'($urandom_range(7)), goal);
                if (pick < 90)
                    send_ticks($urandom_range(1, 12));
                else
                    send_ticks($urandom_range(13, 40));
            end
        end
        push <= 1'b0;

        send_idle_pct  <= 0;
        recv_stall_pct <= 0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d frames still expected at the end", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
